FILE: hw/rtl/mcmac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmac_pkg
// Shared types and constants for the Magma CMAC block.
// ----------------------------------------------------------------------------
package mcmac_pkg;

   localparam int BLOCK_W  = 64;
   localparam int HALF_W   = 32;
   localparam int COUNT_W  = 4;
   localparam int MAC_W    = 32;
   localparam int MAC_BITS = 32;
   localparam int ROUND_W  = 5;
   localparam int KEY_REGS = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [BLOCK_W-1:0] DBL_POLY = BLOCK_W'(8'h1B);

   // register indexes of the key port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_12 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_34 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_56 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_78 = 3'd3;

   typedef logic [BLOCK_W-1:0] key_regs_type [KEY_REGS];

   // one feistel step handed to the round unit
   typedef struct packed {
      logic [HALF_W-1:0] hi;
      logic [HALF_W-1:0] lo;
      logic [HALF_W-1:0] key_word;
      logic              final_round;
   } round_req_type;

endpackage

FILE: hw/rtl/mcmac_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmac_req_if
// Message word channel: one 64-bit block with byte count and last flag.
// ----------------------------------------------------------------------------
interface mcmac_req_if;
   import mcmac_pkg::*;

   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] data_block;
   logic [COUNT_W-1:0] byte_count;
   logic               last;

   modport source (output valid, output data_block, output byte_count, output last,
                   input ready);
   modport sink   (input valid, input data_block, input byte_count, input last,
                   output ready);
endinterface

FILE: hw/rtl/mcmac_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmac_rsp_if
// Result channel: one 32-bit mac word per message.
// ----------------------------------------------------------------------------
interface mcmac_rsp_if;
   import mcmac_pkg::*;

   logic             valid;
   logic             ready;
   logic [MAC_W-1:0] mac;

   modport source (output valid, output mac, input ready);
   modport sink   (input valid, input mac, output ready);
endinterface

FILE: hw/rtl/mcmac_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmac_round
// One Magma round: key add, eight s-boxes, rotate by 11, feistel swap (none on the final round).
// ----------------------------------------------------------------------------
module mcmac_round
   import mcmac_pkg::*;
(
   input  round_req_type        round_req,
   output logic [BLOCK_W-1:0]   round_out
);

   localparam logic [3:0] SBOX [8][16] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
   };

   logic [HALF_W-1:0] sum;
   logic [HALF_W-1:0] subst;
   logic [HALF_W-1:0] mixed;

   always_comb begin
      sum = round_req.lo + round_req.key_word;
      for (int i = 0; i < 8; i++) begin
         subst[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
      end
      mixed = {subst[20:0], subst[31:21]} ^ round_req.hi;
      if (round_req.final_round) begin
         round_out = {mixed, round_req.lo};
      end else begin
         round_out = {round_req.lo, mixed};
      end
   end

endmodule

FILE: hw/rtl/mcmac_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcmac_core
// Round sequencer: subkey derivation, cbc chaining and mac output register.
// ----------------------------------------------------------------------------
module mcmac_core
   import mcmac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  key_regs_type key_regs,
   mcmac_req_if.sink    req_ch,
   mcmac_rsp_if.source  rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUBKEY,
      ST_BLOCK,
      ST_FINISH
   } state_type;

   localparam int MAC_SHIFT = BLOCK_W - MAC_BITS;

   state_type          state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [BLOCK_W-1:0] halves_ff, halves_in;
   logic [BLOCK_W-1:0] chain_ff, chain_in;
   logic [BLOCK_W-1:0] subkey_ff, subkey_in;
   logic               in_msg_ff, in_msg_in;
   logic [BLOCK_W-1:0] data_ff, data_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;

   round_req_type      round_req;
   logic [BLOCK_W-1:0] round_out;
   logic [2:0]         key_idx;
   logic [BLOCK_W-1:0] key_reg;
   logic [BLOCK_W-1:0] shifted;
   logic               accept;

   function automatic logic [BLOCK_W-1:0] dbl(input logic [BLOCK_W-1:0] v);
      return v[BLOCK_W-1] ? ({v[BLOCK_W-2:0], 1'b0} ^ DBL_POLY) : {v[BLOCK_W-2:0], 1'b0};
   endfunction

   // message word; a last word gets the subkey applied, and final-block padding if short
   function automatic logic [BLOCK_W-1:0] build_block(
      input logic [BLOCK_W-1:0] data,
      input logic [COUNT_W-1:0] count,
      input logic               is_last,
      input logic [BLOCK_W-1:0] base
   );
      logic [BLOCK_W-1:0] k1;
      logic [BLOCK_W-1:0] padded;
      k1 = dbl(base);
      for (int i = 0; i < 8; i++) begin
         if (COUNT_W'(i) < count) begin
            padded[BLOCK_W-1-8*i -: 8] = data[BLOCK_W-1-8*i -: 8];
         end else if (COUNT_W'(i) == count) begin
            padded[BLOCK_W-1-8*i -: 8] = 8'h80;
         end else begin
            padded[BLOCK_W-1-8*i -: 8] = 8'h00;
         end
      end
      if (!is_last) begin
         return data;
      end else if (count >= COUNT_W'(8)) begin
         return data ^ k1;
      end else begin
         return padded ^ dbl(k1);
      end
   endfunction

   // key schedule: k1..k8 three times, then k8..k1
   always_comb begin
      key_idx = (round_ff < ROUND_W'(24)) ? round_ff[2:0] : ~round_ff[2:0];
      key_reg = key_regs[key_idx[2:1]];
      round_req.hi          = halves_ff[BLOCK_W-1:HALF_W];
      round_req.lo          = halves_ff[HALF_W-1:0];
      round_req.key_word    = key_idx[0] ? key_reg[HALF_W-1:0] : key_reg[BLOCK_W-1:HALF_W];
      round_req.final_round = (round_ff == '1);
   end

   mcmac_round u_round (
      .round_req (round_req),
      .round_out (round_out)
   );

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.mac    = mac_ff;
   assign shifted       = halves_ff >> MAC_SHIFT;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      halves_in    = halves_ff;
      chain_in     = chain_ff;
      subkey_in    = subkey_ff;
      in_msg_in    = in_msg_ff;
      data_in      = data_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      mac_in       = mac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               data_in  = req_ch.data_block;
               count_in = req_ch.byte_count;
               last_in  = req_ch.last;
               round_in = '0;
               if (!in_msg_ff) begin
                  in_msg_in = 1'b1;
                  chain_in  = '0;
                  halves_in = '0;
                  state_in  = ST_SUBKEY;
               end else begin
                  halves_in = chain_ff ^ build_block(req_ch.data_block, req_ch.byte_count,
                                                     req_ch.last, subkey_ff);
                  state_in  = ST_BLOCK;
               end
            end
         end
         ST_SUBKEY: begin
            round_in = round_ff + ROUND_W'(1);
            if (round_req.final_round) begin
               halves_in = chain_ff;
               subkey_in = round_out;
               halves_in = chain_ff ^ build_block(data_ff, count_ff, last_ff, round_out);
               state_in  = ST_BLOCK;
            end else begin
               halves_in = round_out;
            end
         end
         ST_BLOCK: begin
            round_in  = round_ff + ROUND_W'(1);
            halves_in = round_out;
            if (round_req.final_round) begin
               if (last_ff) begin
                  chain_in  = '0;
                  in_msg_in = 1'b0;
                  state_in  = ST_FINISH;
               end else begin
                  chain_in  = round_out;
                  halves_in = '0;
                  state_in  = ST_IDLE;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               mac_in       = shifted[MAC_W-1:0];
               rsp_valid_in = 1'b1;
               halves_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         halves_ff    <= '0;
         chain_ff     <= '0;
         in_msg_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         halves_ff    <= halves_in;
         chain_ff     <= chain_in;
         in_msg_ff    <= in_msg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      subkey_ff <= subkey_in;
      data_ff   <= data_in;
      count_ff  <= count_in;
      last_ff   <= last_in;
      mac_ff    <= mac_in;
   end

endmodule

FILE: hw/rtl/magma_cmac_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magma_cmac_mac
// Magma CMAC over a stream of 64-bit message words.
// ----------------------------------------------------------------------------
// req_ch carries one big-endian message word with its byte count and a
// last flag; rsp_ch carries one 32-bit mac word for each last word.
// The 256-bit key is written through csr_we / csr_index / csr_wdata as
// four 64-bit registers; the user must write them only while no message
// word is in flight, which the block itself does not enforce.
// A single round unit does one Magma round per cycle: each word runs 32
// rounds after its accept; the first word of a message first runs 32 more
// rounds to derive the subkeys from the encryption of zero.
// After the rounds of a last word, ST_FINISH loads the mac register.
// req_ch.ready is high only while the sequencer is idle; a new word may be
// taken while a mac waits for the receiver, and the block holds a finished
// mac until the previous one is taken.
// Reset clears the key, the chaining value and any message in progress.
// ----------------------------------------------------------------------------
module magma_cmac_mac
   import mcmac_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   mcmac_req_if.sink            req_ch,
   mcmac_rsp_if.source          rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BLOCK_W-1:0]   csr_wdata
);

   key_regs_type key_ff;
   key_regs_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_12: key_in[0] = csr_wdata;
            CSR_KEY_34: key_in[1] = csr_wdata;
            CSR_KEY_56: key_in[2] = csr_wdata;
            CSR_KEY_78: key_in[3] = csr_wdata;
            default: begin
               key_in = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEY_REGS; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         key_ff <= key_in;
      end
   end

   mcmac_core u_core (
      .clock    (clock),
      .reset    (reset),
      .key_regs (key_ff),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch)
   );

endmodule
